[hw/rtl/page_allocator_with_locks_core_macros.svh]
// assertion macros for the page allocator core
// expects clk_i and rst_ni in the scope of use
`ifndef PAGE_ALLOCATOR_WITH_LOCKS_CORE_MACROS_SVH
`define PAGE_ALLOCATOR_WITH_LOCKS_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define PAL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication from an antecedent to a consequent in the next cycle
`define PAL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pal_pkg.sv]
// shared types and constants of the page allocator core
// no dependencies
`default_nettype none

package pal_pkg;

  localparam int unsigned MAX_PAGES     = 1024;
  localparam int unsigned RESERVED_PAGE = 0;

  localparam int unsigned PAGE_W = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned SIZE_W = 17;
  localparam int unsigned ADDR_W = 26;
  localparam int unsigned PROD_W = PAGE_W + SIZE_W;
  localparam int unsigned OP_W   = 3;

  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam logic        REG_PAGE_SIZE = 1'b0;
  localparam logic [SIZE_W-1:0] PAGE_SIZE_RST = SIZE_W'(4096);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_MAP    = 3'd2,
    OP_LOCK   = 3'd3,
    OP_UNLOCK = 3'd4
  } op_e;

  // one page table entry
  typedef struct packed {
    logic valid;
    logic locked;
  } ent_t;

  localparam int unsigned ENT_W = $bits(ent_t);

  localparam ent_t ENT_MAPPED = '{valid: 1'b1, locked: 1'b0};
  localparam ent_t ENT_LOCKED = '{valid: 1'b1, locked: 1'b1};
  localparam ent_t ENT_FREE   = '{valid: 1'b0, locked: 1'b0};

  // allocator state held in flops
  typedef struct packed {
    logic [CNT_W-1:0]  high_water;
    logic [CNT_W-1:0]  free_top;
    logic [CNT_W-1:0]  used_count;
    logic [PAGE_W-1:0] top;      // stack[free_top-1], rest lives in ram
    logic              lock0;    // lock mark of the reserved page
  } state_t;

  // memory writes requested by one operation
  typedef struct packed {
    logic              tbl_we;
    logic [PAGE_W-1:0] tbl_addr;
    ent_t              tbl_data;
    logic              stk_we;
    logic [PAGE_W-1:0] stk_addr;
    logic [PAGE_W-1:0] stk_data;
  } wr_t;

  // one result word
  typedef struct packed {
    logic              ok;
    logic [PAGE_W-1:0] page;
    logic [ADDR_W-1:0] offset;
    logic [CNT_W-1:0]  used;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/pal_ram.sv]
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module pal_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/pal_exec.sv]
// execute logic of one allocator operation: decision, next state, writes
// depends on pal_pkg
`default_nettype none

module pal_exec (
  input  wire pal_pkg::op_e                   op_i,
  input  wire logic [pal_pkg::PAGE_W-1:0]     page_i,
  input  wire logic [pal_pkg::ADDR_W-1:0]     addr_i,
  input  wire logic [pal_pkg::SIZE_W-1:0]     page_size_i,
  input  wire pal_pkg::state_t                st_i,
  input  wire pal_pkg::ent_t                  ent_i,
  input  wire logic [pal_pkg::PAGE_W-1:0]     stk_next_i,
  output pal_pkg::state_t                     st_o,
  output pal_pkg::wr_t                        wr_o,
  output pal_pkg::res_t                       res_o
);

  import pal_pkg::*;

  logic [PAGE_W-1:0] page;
  ent_t              ent;
  logic              below_hw;
  logic              at_hw;
  logic              has_room;
  logic              stack_some;
  logic [PROD_W-1:0] prod;
  logic              addr_match;
  logic              ok;
  logic              give_off;

  // allocate takes the stack top, or the next fresh page
  assign stack_some = (st_i.free_top != '0);
  assign page = (op_i == OP_ALLOC) ?
                (stack_some ? st_i.top : st_i.high_water[PAGE_W-1:0]) : page_i;

  // reserved page is valid from reset and its lock lives in a flop
  assign ent = (page == PAGE_W'(RESERVED_PAGE)) ?
               '{valid: 1'b1, locked: st_i.lock0} : ent_i;

  assign below_hw   = ({1'b0, page} < st_i.high_water);
  assign at_hw      = ({1'b0, page} == st_i.high_water);
  assign has_room   = (st_i.high_water < CNT_W'(MAX_PAGES));
  assign prod       = PROD_W'(page) * PROD_W'(page_size_i);
  assign addr_match = (PROD_W'(addr_i) == prod);

  always_comb begin
    st_o        = st_i;
    wr_o        = '0;
    ok          = 1'b0;
    give_off    = 1'b0;
    wr_o.tbl_addr = page;

    case (op_i)
      OP_ALLOC: begin
        if (stack_some) begin
          ok            = 1'b1;
          give_off      = 1'b1;
          st_o.free_top = st_i.free_top - CNT_W'(1);
          st_o.top      = stk_next_i;
          // a popped page that map revived stays as it is
          if (!ent.valid) begin
            wr_o.tbl_we     = 1'b1;
            wr_o.tbl_data   = ENT_MAPPED;
            st_o.used_count = st_i.used_count + CNT_W'(1);
          end
        end else if (has_room) begin
          ok              = 1'b1;
          give_off        = 1'b1;
          wr_o.tbl_we     = 1'b1;
          wr_o.tbl_data   = ENT_MAPPED;
          st_o.high_water = st_i.high_water + CNT_W'(1);
          st_o.used_count = st_i.used_count + CNT_W'(1);
        end
      end
      OP_FREE: begin
        if (page != PAGE_W'(RESERVED_PAGE) && below_hw && ent.valid && !ent.locked) begin
          ok              = 1'b1;
          wr_o.tbl_we     = 1'b1;
          wr_o.tbl_data   = ENT_FREE;
          st_o.used_count = st_i.used_count - CNT_W'(1);
          // full stack drops the push
          if (st_i.free_top < CNT_W'(MAX_PAGES)) begin
            if (stack_some) begin
              wr_o.stk_we   = 1'b1;
              wr_o.stk_addr = PAGE_W'(st_i.free_top - CNT_W'(1));
              wr_o.stk_data = st_i.top;
            end
            st_o.top      = page;
            st_o.free_top = st_i.free_top + CNT_W'(1);
          end
        end
      end
      OP_MAP: begin
        if (below_hw) begin
          ok       = 1'b1;
          give_off = 1'b1;
          if (!ent.valid) begin
            wr_o.tbl_we     = 1'b1;
            wr_o.tbl_data   = ENT_MAPPED;
            st_o.used_count = st_i.used_count + CNT_W'(1);
          end
        end else if (at_hw && has_room) begin
          ok              = 1'b1;
          give_off        = 1'b1;
          wr_o.tbl_we     = 1'b1;
          wr_o.tbl_data   = ENT_MAPPED;
          st_o.high_water = st_i.high_water + CNT_W'(1);
          st_o.used_count = st_i.used_count + CNT_W'(1);
        end
      end
      OP_LOCK: begin
        if (below_hw && ent.valid && !ent.locked) begin
          ok            = 1'b1;
          give_off      = 1'b1;
          wr_o.tbl_we   = 1'b1;
          wr_o.tbl_data = ENT_LOCKED;
          if (page == PAGE_W'(RESERVED_PAGE)) begin
            st_o.lock0 = 1'b1;
          end
        end
      end
      OP_UNLOCK: begin
        if (below_hw && ent.valid && ent.locked && addr_match) begin
          ok            = 1'b1;
          wr_o.tbl_we   = 1'b1;
          wr_o.tbl_data = ENT_MAPPED;
          if (page == PAGE_W'(RESERVED_PAGE)) begin
            st_o.lock0 = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.ok     = ok;
  assign res_o.page   = ok ? page : '0;
  assign res_o.offset = (ok && give_off) ? prod[ADDR_W-1:0] : '0;
  assign res_o.used   = st_o.used_count;

endmodule

`default_nettype wire

[hw/rtl/page_allocator_with_locks_core.sv]
// top level of the page allocator with lock marks
// depends on pal_pkg, pal_ram, pal_exec and the assertion macro header
`default_nettype none

// Page allocator: a page table (valid and lock mark per page), a high-water
// count and a LIFO stack of freed pages. Each input word is one operation
// (allocate, free, map, lock, unlock) and gives exactly one result word.
// Throughput is one word per cycle while the output is not stalled. The word
// is accepted into an execute register while the page table ram and the
// stack ram are read (registered reads), the operation is decided there and
// written back, and the result sits in an output register, so a new word is
// taken while the last result waits. A write-back hitting the address read
// for the next word is forwarded. There is no clearing pass after reset:
// table entries at or above the high-water count are never trusted, and the
// reserved page keeps its marks in flops. page_size is written through the
// APB port at byte address 0; the user must write it only while the block is
// idle, the block itself does not enforce this.
module page_allocator_with_locks_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input words
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [pal_pkg::OP_W-1:0]      opcode_i,
  input  wire logic [pal_pkg::PAGE_W-1:0]    in_page_i,
  input  wire logic [pal_pkg::ADDR_W-1:0]    in_address_i,
  // result words
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               ok_o,
  output logic      [pal_pkg::PAGE_W-1:0]    out_page_o,
  output logic      [pal_pkg::ADDR_W-1:0]    page_offset_o,
  output logic      [pal_pkg::CNT_W-1:0]     used_pages_o,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pal_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [pal_pkg::PDATA_W-1:0]   pwdata,
  output logic      [pal_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  import pal_pkg::*;

  `include "page_allocator_with_locks_core_macros.svh"

  // configuration
  logic [SIZE_W-1:0] page_size_q;
  logic              cfg_we;

  // allocator state
  state_t st_q, st_d, st_nx;
  wr_t    wr;
  res_t   res;

  // execute register
  logic              s1_valid_q;
  op_e               s1_op_q;
  logic [PAGE_W-1:0] s1_page_q;
  logic [ADDR_W-1:0] s1_addr_q;

  // write-back forwarding for the reads launched at accept
  logic              tbl_hit_q;
  ent_t              tbl_fwd_q;
  logic              stk_hit_q;
  logic [PAGE_W-1:0] stk_fwd_q;

  // output register
  logic  out_valid_q;
  res_t  out_q;

  // handshake
  logic out_ready;
  logic retire;
  logic accept;

  // ram ports
  logic [PAGE_W-1:0] tbl_raddr;
  logic [ENT_W-1:0]  tbl_rdata;
  logic [PAGE_W-1:0] stk_raddr;
  logic [PAGE_W-1:0] stk_rdata;
  logic              tbl_we;
  logic              stk_we;
  ent_t              ent;
  logic [PAGE_W-1:0] stk_next;

  // apb: always ready, one register at word 0
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_PAGE_SIZE);
  assign prdata = (paddr[2] == REG_PAGE_SIZE) ? PDATA_W'(page_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_size_q <= PAGE_SIZE_RST;
    end else if (cfg_we) begin
      page_size_q <= pwdata[SIZE_W-1:0];
    end
  end

  // the execute word moves on when the output register can take it
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign retire     = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  // forwarded read data for the word in execute
  assign ent      = tbl_hit_q ? tbl_fwd_q : ent_t'(tbl_rdata);
  assign stk_next = stk_hit_q ? stk_fwd_q : stk_rdata;

  pal_exec u_exec (
    .op_i        (s1_op_q),
    .page_i      (s1_page_q),
    .addr_i      (s1_addr_q),
    .page_size_i (page_size_q),
    .st_i        (st_q),
    .ent_i       (ent),
    .stk_next_i  (stk_next),
    .st_o        (st_nx),
    .wr_o        (wr),
    .res_o       (res)
  );

  assign st_d   = retire ? st_nx : st_q;
  assign tbl_we = retire && wr.tbl_we;
  assign stk_we = retire && wr.stk_we;

  // read addresses for the incoming word follow the state after the
  // word in execute: allocate reads the page it will pop or grow into,
  // and every word reads the stack entry just below the top
  always_comb begin
    if (opcode_i == OP_ALLOC) begin
      tbl_raddr = (st_d.free_top != '0) ? st_d.top : st_d.high_water[PAGE_W-1:0];
    end else begin
      tbl_raddr = in_page_i;
    end
  end
  assign stk_raddr = PAGE_W'(st_d.free_top - CNT_W'(2));

  pal_ram #(
    .Width (ENT_W),
    .Depth (MAX_PAGES)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (wr.tbl_addr),
    .wdata_i (wr.tbl_data),
    .re_i    (accept),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  pal_ram #(
    .Width (PAGE_W),
    .Depth (MAX_PAGES)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (wr.stk_addr),
    .wdata_i (wr.stk_data),
    .re_i    (accept),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.high_water <= CNT_W'(1);
      st_q.free_top   <= '0;
      st_q.used_count <= CNT_W'(1);
      st_q.top        <= '0;
      st_q.lock0      <= 1'b0;
      s1_valid_q      <= 1'b0;
      tbl_hit_q       <= 1'b0;
      stk_hit_q       <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      st_q <= st_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
        // write at the same edge as the read: ram returns old data
        tbl_hit_q  <= tbl_we && (wr.tbl_addr == tbl_raddr);
        stk_hit_q  <= stk_we && (wr.stk_addr == stk_raddr);
      end else if (retire) begin
        s1_valid_q <= 1'b0;
      end
      if (retire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= op_e'(opcode_i);
      s1_page_q <= in_page_i;
      s1_addr_q <= in_address_i;
      tbl_fwd_q <= wr.tbl_data;
      stk_fwd_q <= wr.stk_data;
    end
    if (retire) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_q.ok;
  assign out_page_o    = out_q.page;
  assign page_offset_o = out_q.offset;
  assign used_pages_o  = out_q.used;

  // used count never exceeds the high-water count, since every valid page lies below it
  `PAL_ASSERT(a_used_le_hw, st_q.used_count <= st_q.high_water, "used count above high water")
  // used count moves by at most one page per cycle
  `PAL_ASSERT_NEXT(a_used_step, 1'b1,
    (st_q.used_count == $past(st_q.used_count)) ||
    (st_q.used_count == $past(st_q.used_count) + CNT_W'(1)) ||
    (st_q.used_count == $past(st_q.used_count) - CNT_W'(1)), "used count jumped")
  // a blocked execute word is never lost
  `PAL_ASSERT_NEXT(a_s1_hold, s1_valid_q && !out_ready, s1_valid_q, "execute word dropped")
  // a result appears only from a retiring execute word
  `PAL_ASSERT_NEXT(a_out_src, !retire && !out_valid_q, !out_valid_q, "result without source")

endmodule

`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for the page allocator core with lock marks
// needs pal_pkg and page_allocator_with_locks_core; predicts every result word in-line

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pal_pkg::*;

  // opcodes the block must refuse
  localparam logic [OP_W-1:0] OP_BAD_FIRST = OP_W'(5);
  localparam logic [OP_W-1:0] OP_BAD_LAST  = OP_W'(7);

  localparam logic [PADDR_W-1:0] PAGE_SIZE_ADDR = PADDR_W'({REG_PAGE_SIZE, 2'b00});
  localparam logic [SIZE_W-1:0]  SIZE_ALL_ONES  = {SIZE_W{1'b1}};

  localparam int unsigned DRAIN_CYCLES = 4;     // result latency plus margin
  localparam int unsigned QUIET_LIMIT  = 5000;  // cycles with no handshake at all
  localparam int unsigned PHASE_WORDS  = 205;

  // one operation word as it goes into the block
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [PAGE_W-1:0] page;
    logic [ADDR_W-1:0] addr;
  } op_word_t;

  // whole allocator state kept by the predictor
  typedef struct packed {
    logic [MAX_PAGES-1:0]        valid;
    logic [MAX_PAGES-1:0]        locked;
    logic [MAX_PAGES*PAGE_W-1:0] stack;
    logic [CNT_W-1:0]            high_water;
    logic [CNT_W-1:0]            free_top;
    logic [CNT_W-1:0]            used;
    logic [SIZE_W-1:0]           page_size;
  } alloc_state_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // input side
  logic     in_valid = 1'b0;
  op_word_t cur_word = '0;
  logic     in_stall_o;

  // result side
  logic              out_valid_o;
  logic              out_stall = 1'b0;
  logic              ok_o;
  logic [PAGE_W-1:0] out_page_o;
  logic [ADDR_W-1:0] page_offset_o;
  logic [CNT_W-1:0]  used_pages_o;

  // config port
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // model_st follows accepted words, plan_st runs ahead while words are queued
  alloc_state_t model_st;
  alloc_state_t plan_st;

  op_word_t    pending_words[$];   // queued, not yet presented
  res_t        results_due[$];     // predicted, not yet seen at the output
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_cnt       = 0;
  int unsigned quiet_cycles   = 0;

  page_allocator_with_locks_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .opcode_i     (cur_word.opcode),
    .in_page_i    (cur_word.page),
    .in_address_i (cur_word.addr),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .ok_o         (ok_o),
    .out_page_o   (out_page_o),
    .page_offset_o(page_offset_o),
    .used_pages_o (used_pages_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // full-width page base, 27 bits so an oversized product never matches an address
  function automatic logic [PROD_W-1:0] page_product(input logic [PAGE_W-1:0] pg,
                                                      input logic [SIZE_W-1:0] sz);
    return PROD_W'(pg) * PROD_W'(sz);
  endfunction

  // bring page p into use; p may be at most the high-water count
  function automatic logic take_page(inout alloc_state_t s, input logic [CNT_W-1:0] p);
    if (p < s.high_water) begin
      if (!s.valid[p[PAGE_W-1:0]]) begin
        s.valid[p[PAGE_W-1:0]]  = 1'b1;
        s.locked[p[PAGE_W-1:0]] = 1'b0;
        s.used = s.used + 1'b1;
      end
      return 1'b1;
    end
    // growing the table, refused once every page has been handed out
    if (p == s.high_water && s.high_water < MAX_PAGES) begin
      s.valid[p[PAGE_W-1:0]]  = 1'b1;
      s.locked[p[PAGE_W-1:0]] = 1'b0;
      s.high_water = s.high_water + 1'b1;
      s.used = s.used + 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one operation word to s and return the result word it gives
  function automatic res_t apply_op(inout alloc_state_t s, input op_word_t w);
    res_t             r;
    logic [CNT_W-1:0] p;
    logic             with_offset;
    r = '0;
    p = '0;
    with_offset = 1'b0;
    case (w.opcode)
      OP_ALLOC: begin
        // last freed page first, else the next never-used page
        if (s.free_top != '0) begin
          s.free_top = s.free_top - 1'b1;
          p = CNT_W'(s.stack[s.free_top*PAGE_W +: PAGE_W]);
        end else begin
          p = s.high_water;
        end
        r.ok = take_page(s, p);
        with_offset = 1'b1;
      end
      OP_FREE: begin
        if (w.page != RESERVED_PAGE && CNT_W'(w.page) < s.high_water &&
            s.valid[w.page] && !s.locked[w.page]) begin
          s.valid[w.page] = 1'b0;
          // a full stack drops the push, the page is still released
          if (s.free_top < MAX_PAGES) begin
            s.stack[s.free_top*PAGE_W +: PAGE_W] = w.page;
            s.free_top = s.free_top + 1'b1;
          end
          s.used = s.used - 1'b1;
          r.ok = 1'b1;
          p = CNT_W'(w.page);
        end
      end
      OP_MAP: begin
        if (CNT_W'(w.page) <= s.high_water) begin
          r.ok = take_page(s, CNT_W'(w.page));
        end
        p = CNT_W'(w.page);
        with_offset = 1'b1;
      end
      OP_LOCK: begin
        if (CNT_W'(w.page) < s.high_water && s.valid[w.page] && !s.locked[w.page]) begin
          s.locked[w.page] = 1'b1;
          r.ok = 1'b1;
          p = CNT_W'(w.page);
          with_offset = 1'b1;
        end
      end
      OP_UNLOCK: begin
        if (CNT_W'(w.page) < s.high_water && s.valid[w.page] && s.locked[w.page] &&
            PROD_W'(w.addr) == page_product(w.page, s.page_size)) begin
          s.locked[w.page] = 1'b0;
          r.ok = 1'b1;
          p = CNT_W'(w.page);
        end
      end
      default: begin
        // unused opcodes change nothing
      end
    endcase
    if (r.ok) begin
      r.page = p[PAGE_W-1:0];
      if (with_offset) begin
        r.offset = ADDR_W'(page_product(r.page, s.page_size));
      end
    end
    r.used = s.used;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      fail_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued words, predicts each one as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    op_word_t next_word;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        results_due.push_back(apply_op(model_st, cur_word));
      end
      // a stalled word stays put; otherwise load the next one or idle
      if (!in_valid || !in_stall_o) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = pending_words.pop_front();
          in_valid <= 1'b1;
          cur_word <= next_word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each taken result word with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: result word with nothing predicted, ok %0d page %0d", $time,
                   ok_o, out_page_o);
          fail_cnt++;
        end else begin
          want = results_due.pop_front();
          check_field("ok", 32'(want.ok), 32'(ok_o));
          check_field("out_page", 32'(want.page), 32'(out_page_o));
          check_field("page_offset", 32'(want.offset), 32'(page_offset_o));
          check_field("used_pages", 32'(want.used), 32'(used_pages_o));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // queue a word, moving the planning copy along so later words can aim at it
  task automatic queue_word(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] pg,
                            input logic [ADDR_W-1:0] addr);
    op_word_t w;
    w.opcode = op;
    w.page   = pg;
    w.addr   = addr;
    void'(apply_op(plan_st, w));
    pending_words.push_back(w);
  endtask

  // wait until every queued word went in and every result came out
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // setup and access cycle on the config port, only register is page_size
  task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PAGE_SIZE_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write page_size, read it back, and update both predictor copies
  task automatic set_page_size(input logic [SIZE_W-1:0] sz);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b1, PDATA_W'(sz), rd);
    apb_access(1'b0, '0, rd);
    check_field("page_size", 32'(sz), 32'(rd));
    model_st.page_size = sz;
    plan_st.page_size  = sz;
  endtask

  task automatic queue_random_word();
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] pg;
    logic [ADDR_W-1:0] addr;
    logic [PROD_W-1:0] base;
    int unsigned       lim;
    int unsigned       pick;
    int unsigned       tries;
    lim  = (plan_st.high_water < MAX_PAGES) ? plan_st.high_water : MAX_PAGES - 1;
    pick = $urandom_range(99);
    if (pick < 28) op = OP_ALLOC;
    else if (pick < 52) op = OP_FREE;
    else if (pick < 64) op = OP_MAP;
    else if (pick < 80) op = OP_LOCK;
    else if (pick < 95) op = OP_UNLOCK;
    else op = OP_W'($urandom_range(OP_BAD_LAST, OP_BAD_FIRST));
    // mostly pages in use or the next one, now and then anything
    pg = ($urandom_range(9) < 8) ? PAGE_W'($urandom_range(lim)) : PAGE_W'($urandom);
    // aim most free, lock and unlock words at a page they can act on
    if ((op == OP_FREE || op == OP_LOCK || op == OP_UNLOCK) && $urandom_range(3) != 0) begin
      tries = 0;
      while (tries < 8 && !(plan_st.valid[pg] && plan_st.locked[pg] == (op == OP_UNLOCK))) begin
        pg = PAGE_W'($urandom_range(lim));
        tries++;
      end
    end
    // unlock mostly with the right address, sometimes one off or random
    base = page_product(pg, plan_st.page_size);
    pick = $urandom_range(9);
    if (op == OP_UNLOCK && pick < 7) addr = ADDR_W'(base);
    else if (op == OP_UNLOCK && pick == 7) addr = ADDR_W'(base + 1'b1);
    else addr = ADDR_W'($urandom);
    queue_word(op, pg, addr);
  endtask

  task automatic run_random_phase(input logic [SIZE_W-1:0] sz, input int unsigned idle_pct,
                                  input int unsigned stall_pct, input int unsigned count);
    wait_idle();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    set_page_size(sz);
    repeat (count) queue_random_word();
  endtask

  initial begin
    logic [PDATA_W-1:0] rd;
    // state right after reset
    model_st = '0;
    model_st.valid[RESERVED_PAGE] = 1'b1;
    model_st.high_water = CNT_W'(1);
    model_st.used       = CNT_W'(1);
    model_st.page_size  = PAGE_SIZE_RST;
    plan_st = model_st;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    apb_access(1'b0, '0, rd);
    check_field("page_size", 32'(PAGE_SIZE_RST), 32'(rd));

    // directed words at the reset page size, no idling
    queue_word(OP_ALLOC, '0, '0);                           // grows to page 1
    queue_word(OP_ALLOC, '1, '1);                           // grows to page 2
    queue_word(OP_MAP, PAGE_W'(3), '0);                     // page equal to high water
    queue_word(OP_MAP, PAGE_W'(2), '0);                     // already valid, no change
    queue_word(OP_MAP, PAGE_W'(10), '0);                    // above high water, refused
    queue_word(OP_FREE, PAGE_W'(RESERVED_PAGE), '0);        // reserved page refused
    queue_word(OP_FREE, PAGE_W'(1), '0);                    // goes on the stack
    queue_word(OP_FREE, PAGE_W'(1), '0);                    // already free
    queue_word(OP_FREE, PAGE_W'(50), '0);                   // at or above high water
    queue_word(OP_LOCK, PAGE_W'(2), '0);
    queue_word(OP_LOCK, PAGE_W'(2), '0);                    // already locked
    queue_word(OP_FREE, PAGE_W'(2), '0);                    // locked page refused
    queue_word(OP_UNLOCK, PAGE_W'(2), ADDR_W'(page_product(PAGE_W'(2), PAGE_SIZE_RST) + 1'b1));
    queue_word(OP_UNLOCK, PAGE_W'(2), ADDR_W'(page_product(PAGE_W'(2), PAGE_SIZE_RST)));
    queue_word(OP_UNLOCK, PAGE_W'(2), ADDR_W'(page_product(PAGE_W'(2), PAGE_SIZE_RST)));
    queue_word(OP_LOCK, PAGE_W'(RESERVED_PAGE), '0);        // reserved page can be locked
    queue_word(OP_UNLOCK, PAGE_W'(RESERVED_PAGE), '0);
    queue_word(OP_MAP, PAGE_W'(1), '0);                     // freed page made valid again
    queue_word(OP_ALLOC, '0, '0);                           // pops that page, count unchanged
    queue_word(OP_BAD_FIRST, PAGE_W'(2), '0);
    queue_word(OP_BAD_LAST, '1, '1);
    queue_word(OP_LOCK, '1, '1);                            // far above high water
    queue_word(OP_UNLOCK, '1, '1);
    queue_word(OP_ALLOC, '0, '0);

    // random words, the page size and pacing change between phases
    run_random_phase(SIZE_W'(65536), 76, 0, PHASE_WORDS);
    run_random_phase('0, 0, 76, PHASE_WORDS);
    run_random_phase(SIZE_ALL_ONES, 0, 0, PHASE_WORDS);
    run_random_phase(SIZE_W'($urandom_range(SIZE_ALL_ONES, 2)), 6, 6, PHASE_WORDS);
    run_random_phase(PAGE_SIZE_RST, 76, 0, PHASE_WORDS);

    wait_idle();
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
